// File: hdl/cslx_pkg.sv
// ----------------------------------------------------------------------------
// cslx_pkg
// Shared types and constants for the c subset lexer: token classes, keyword
// table and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cslx_pkg;

   // token classes as seen on the result channel
   localparam logic [2:0] CLS_OPER    = 3'd0;
   localparam logic [2:0] CLS_SPECIAL = 3'd1;
   localparam logic [2:0] CLS_DIGIT   = 3'd2;
   localparam logic [2:0] CLS_KEYWORD = 3'd3;
   localparam logic [2:0] CLS_IDENT   = 3'd4;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // keyword table, one character slot per position, zero past the end
   localparam int KW_COUNT = 6;
   localparam int KW_SLOTS = 8;

   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"m", "a", "i", "n",   8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e",   8'h00, 8'h00, 8'h00, 8'h00},
      '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l",   "e",   8'h00, 8'h00, 8'h00}
   };

   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5};

   // controller to datapath
   typedef struct packed {
      logic capture;      // latch the accepted input word
      logic append;       // write byte into the word buffer, grow the word
      logic line_inc;     // count a newline
      logic emit_single;  // load a one-character token into the output register
      logic flush_start;  // rewind the replay pointer
      logic emit_char;    // load one buffered character into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic eot;          // captured word is an end marker
      logic word_open;    // an identifier is pending
      logic word_room;    // the buffer can take another character
      logic alnum;        // letter or digit
      logic letter;
      logic tok;          // operator, special symbol or digit
      logic newline;
      logic last_char;    // replay pointer is on the last buffered character
      logic out_free;     // output register can be loaded this cycle
   } sts_type;

endpackage

// File: hdl/cslx_ctrl.sv
// ----------------------------------------------------------------------------
// cslx_ctrl
// Sequencer of the lexer: accepts one word, classifies it, replays a pending
// identifier character by character and issues datapath commands.
// ----------------------------------------------------------------------------
module cslx_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cslx_pkg::sts_type sts,
   output cslx_pkg::cmd_type cmd
);
   import cslx_pkg::*;

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_CLASSIFY = 2'd1;
   localparam logic [1:0] ST_FETCH    = 2'd2;
   localparam logic [1:0] ST_EMIT     = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            priority if (sts.eot) begin
               if (sts.word_open) begin
                  cmd.flush_start = 1'b1;
                  state_in        = ST_FETCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (sts.word_open && sts.alnum && sts.word_room) begin
               cmd.append = 1'b1;
               state_in   = ST_IDLE;
            end else if (sts.word_open) begin
               cmd.flush_start = 1'b1;
               state_in        = ST_FETCH;
            end else if (sts.tok) begin
               if (sts.out_free) begin
                  cmd.emit_single = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else if (sts.letter) begin
               cmd.append = 1'b1;
               state_in   = ST_IDLE;
            end else if (sts.newline) begin
               cmd.line_inc = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_char = 1'b1;
               state_in      = sts.last_char ? ST_CLASSIFY : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_single || cmd.emit_char) |-> sts.out_free)
      else $error("output register loaded while occupied and stalled");

   a_capture_then_classify : assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_CLASSIFY))
      else $error("captured word not classified next cycle");

   a_fetch_then_emit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |=> (state_ff == ST_EMIT))
      else $error("buffer read not followed by emit");

endmodule

// File: hdl/cslx_dp.sv
// ----------------------------------------------------------------------------
// cslx_dp
// Lexer datapath: input word register, byte classifier, identifier buffer
// with incremental keyword match, line and token counters, output register.
// ----------------------------------------------------------------------------
module cslx_dp #(
   parameter int MAX_WORD   = 19,
   parameter int COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_source_byte,
   input  logic              req_end_of_text,
   input  cslx_pkg::cmd_type cmd,
   output cslx_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_token_class,
   output logic [15:0]       rsp_line_number,
   output logic [15:0]       rsp_token_number,
   output logic [7:0]        rsp_lexeme_char,
   output logic              rsp_lexeme_end,
   output logic              rsp_run_last
);
   import cslx_pkg::*;

   localparam int LEN_W  = $clog2(MAX_WORD + 1);
   localparam int ADDR_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int POS_W  = (LEN_W > 3) ? LEN_W : 3;

   // captured input word
   logic [7:0] byte_ff;
   logic       eot_ff;

   // identifier state
   logic [7:0]          mem [MAX_WORD];
   logic [7:0]          rd_data_ff;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    ptr_ff, ptr_in;
   logic [KW_COUNT-1:0] mask_ff, mask_in;

   // counters
   logic [COUNT_BITS-1:0] line_ff, line_in;
   logic [COUNT_BITS-1:0] token_ff, token_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_class_ff;
   logic [15:0] rsp_line_ff;
   logic [15:0] rsp_token_ff;
   logic [7:0]  rsp_char_ff;
   logic        rsp_lexeme_end_ff;
   logic        rsp_run_last_ff;

   logic             is_letter, is_digit, is_oper, is_special, is_tok;
   logic [2:0]       tok_class;
   logic             word_open, last_char, out_free, is_keyword, load;
   logic [POS_W-1:0] len_wide;
   logic [2:0]       pos;
   logic             pos_ok;
   logic [KW_COUNT-1:0] mask_base, len_eq;

   // byte classifier
   always_comb begin
      is_letter  = (byte_ff >= "a" && byte_ff <= "z") || (byte_ff >= "A" && byte_ff <= "Z");
      is_digit   = (byte_ff >= "0" && byte_ff <= "9");
      is_oper    = (byte_ff == "+") || (byte_ff == "-") || (byte_ff == "*") ||
                   (byte_ff == "/");
      is_special = (byte_ff == ";") || (byte_ff == "{") || (byte_ff == "}") ||
                   (byte_ff == "(") || (byte_ff == ")") || (byte_ff == "?") ||
                   (byte_ff == "@") || (byte_ff == "!") || (byte_ff == "%");
      is_tok     = is_oper || is_special || is_digit;
      priority if (is_oper)    tok_class = CLS_OPER;
      else if (is_special)     tok_class = CLS_SPECIAL;
      else                     tok_class = CLS_DIGIT;
   end

   // keyword match, updated one character at a time
   always_comb begin
      len_wide  = POS_W'(len_ff);
      pos_ok    = ((len_wide >> 3) == '0);
      pos       = len_wide[2:0];
      word_open = (len_ff != '0);
      mask_base = word_open ? mask_ff : '1;
      for (int j = 0; j < KW_COUNT; j++) begin
         mask_in[j] = mask_base[j] && pos_ok && (KW_TEXT[j][pos] == byte_ff);
         len_eq[j]  = (len_wide == POS_W'(KW_LEN[j]));
      end
      is_keyword = |(mask_ff & len_eq);
   end

   assign last_char = ((ptr_ff + LEN_W'(1)) == len_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = cmd.emit_single || cmd.emit_char;

   always_comb begin
      sts           = '0;
      sts.eot       = eot_ff;
      sts.word_open = word_open;
      sts.word_room = (len_ff < LEN_W'(MAX_WORD));
      sts.alnum     = is_letter || is_digit;
      sts.letter    = is_letter;
      sts.tok       = is_tok;
      sts.newline   = (byte_ff == CHAR_NEWLINE);
      sts.last_char = last_char;
      sts.out_free  = out_free;
   end

   // next state of counters and pointers
   always_comb begin
      len_in   = len_ff;
      ptr_in   = ptr_ff;
      line_in  = line_ff;
      token_in = token_ff;
      if (cmd.append) begin
         len_in = len_ff + LEN_W'(1);
      end
      if (cmd.line_inc) begin
         line_in = line_ff + COUNT_BITS'(1);
      end
      if (cmd.emit_single) begin
         token_in = token_ff + COUNT_BITS'(1);
      end
      if (cmd.flush_start) begin
         ptr_in = '0;
      end
      if (cmd.emit_char) begin
         if (last_char) begin
            len_in   = '0;
            token_in = token_ff + COUNT_BITS'(1);
         end else begin
            ptr_in = ptr_ff + LEN_W'(1);
         end
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ptr_ff       <= '0;
         line_ff      <= COUNT_BITS'(1);
         token_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         line_ff      <= line_in;
         token_ff     <= token_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_ff <= req_source_byte;
         eot_ff  <= req_end_of_text;
      end
      if (cmd.append) begin
         mask_ff <= mask_in;
      end
      if (load) begin
         rsp_line_ff  <= 16'(line_ff);
         rsp_token_ff <= 16'(token_ff);
         if (cmd.emit_char) begin
            rsp_class_ff      <= is_keyword ? CLS_KEYWORD : CLS_IDENT;
            rsp_char_ff       <= rd_data_ff;
            rsp_lexeme_end_ff <= last_char;
            rsp_run_last_ff   <= last_char && (eot_ff || !is_tok);
         end else begin
            rsp_class_ff      <= tok_class;
            rsp_char_ff       <= byte_ff;
            rsp_lexeme_end_ff <= 1'b1;
            rsp_run_last_ff   <= 1'b1;
         end
      end
   end

   // identifier buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[len_ff[ADDR_W-1:0]] <= byte_ff;
      end
      rd_data_ff <= mem[ptr_ff[ADDR_W-1:0]];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_class  = rsp_class_ff;
   assign rsp_line_number  = rsp_line_ff;
   assign rsp_token_number = rsp_token_ff;
   assign rsp_lexeme_char  = rsp_char_ff;
   assign rsp_lexeme_end   = rsp_lexeme_end_ff;
   assign rsp_run_last     = rsp_run_last_ff;

   a_len_bounded : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_WORD))
      else $error("word length beyond buffer depth");

   a_replay_nonempty : assert property (@(posedge clock) disable iff (reset)
      cmd.emit_char |-> (len_ff != '0))
      else $error("replay of an empty identifier");

   a_flush_closes_word : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_char && last_char) |=> ((len_ff == '0) && rsp_lexeme_end_ff))
      else $error("identifier not closed after its last character");

endmodule

// File: hdl/c_subset_lexer_unit.sv
// ----------------------------------------------------------------------------
// c_subset_lexer_unit
// Byte-serial lexer for a small c subset: operators, special symbols, digits,
// keywords and identifiers, tagged with line and token numbers.
// ----------------------------------------------------------------------------
// sequence: a one-character token is loaded into the output register from the
//   classify state once that register is free; the word that ends a pending
//   identifier is followed by a fetch (buffer read) and an emit (output load)
//   per character, and the terminating byte is classified after the last one
// a new word is accepted only in the idle state, so a word that flushes an
//   identifier holds off the next one (the terminator is always reclassified)
// reset: line counter 1, token counter 0, no pending identifier, output empty;
//   the identifier buffer is not cleared, only written entries are read
// ----------------------------------------------------------------------------
module c_subset_lexer_unit #(
   parameter int MAX_WORD   = 19,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request side, one source byte or end marker per word
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_source_byte,
   input  logic        req_end_of_text,
   // response side, one lexeme character per word
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_class,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_token_number,
   output logic [7:0]  rsp_lexeme_char,
   output logic        rsp_lexeme_end,
   output logic        rsp_run_last
);
   import cslx_pkg::*;

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: idle, classify, then fetch/emit per buffered character
   cslx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: classifier, identifier buffer, counters, output register
   cslx_dp #(
      .MAX_WORD   (MAX_WORD),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_source_byte  (req_source_byte),
      .req_end_of_text  (req_end_of_text),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_class  (rsp_token_class),
      .rsp_line_number  (rsp_line_number),
      .rsp_token_number (rsp_token_number),
      .rsp_lexeme_char  (rsp_lexeme_char),
      .rsp_lexeme_end   (rsp_lexeme_end),
      .rsp_run_last     (rsp_run_last)
   );

endmodule
